/* hdl/tlq_pkg.sv */
// Package for the three-level ready-queue scheduler: payload structs, codes,
// sequencer states and reset values. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tlq_pkg;

   localparam int TLQ_QUEUE_DEPTH = 32;
   localparam int TLQ_ID_BITS     = 8;
   localparam int TLQ_BURST_BITS  = 20;
   localparam int TLQ_PRIO_BITS   = 8;
   localparam int TLQ_CSR_BITS    = 8;
   localparam int TLQ_CSR_IDX_W   = 1;

   // Entry widths of the three level stores.
   localparam int TLQ_L1_W = TLQ_ID_BITS + TLQ_BURST_BITS;
   localparam int TLQ_L2_W = TLQ_ID_BITS + TLQ_PRIO_BITS;
   localparam int TLQ_L3_W = TLQ_ID_BITS;

   localparam logic [TLQ_CSR_BITS-1:0] TLQ_HIGH_THR_RESET = 8'd100;
   localparam logic [TLQ_CSR_BITS-1:0] TLQ_LOW_THR_RESET  = 8'd50;

   localparam logic [TLQ_CSR_IDX_W-1:0] TLQ_CSR_HIGH_THR = 1'd0;
   localparam logic [TLQ_CSR_IDX_W-1:0] TLQ_CSR_LOW_THR  = 1'd1;

   localparam logic [1:0] TLQ_LVL_ONE   = 2'd0;
   localparam logic [1:0] TLQ_LVL_TWO   = 2'd1;
   localparam logic [1:0] TLQ_LVL_THREE = 2'd2;

   typedef enum logic [1:0] {
      TLQ_MODE_INSERT = 2'd0,
      TLQ_MODE_BLOCK  = 2'd1,
      TLQ_MODE_YIELD  = 2'd2
   } tlq_mode_type;

   typedef enum logic [2:0] {
      TLQ_IDLE,
      TLQ_DECIDE,
      TLQ_SCAN,
      TLQ_PLACE,
      TLQ_FRONT,
      TLQ_RESP
   } tlq_state_type;

   typedef struct packed {
      logic [1:0]                mode;
      logic [TLQ_ID_BITS-1:0]    thread_id;
      logic [TLQ_PRIO_BITS-1:0]  priority_req;
      logic [TLQ_BURST_BITS-1:0] burst;
   } tlq_req_type;

   typedef struct packed {
      logic                   switch_valid;
      logic [TLQ_ID_BITS-1:0] next_thread_id;
      logic [1:0]             from_level;
      logic [1:0]             queued_level;
      logic                   queue_full;
   } tlq_rsp_type;

   // Per-level store operation issued by the sequencer.
   typedef struct packed {
      logic wr_en;
      logic push;
      logic pop;
   } tlq_qop_type;

endpackage

`default_nettype wire

/* hdl/tlq_queue.sv */
// One ready-queue store: a circular buffer in a memory with head and fill count.
// Addresses are logical (0 is the front). Uses tlq_pkg for the operation struct.
`timescale 1ns / 1ps
`default_nettype none

module tlq_queue #(
   parameter int QUEUE_DEPTH = tlq_pkg::TLQ_QUEUE_DEPTH,
   parameter int ENTRY_W     = tlq_pkg::TLQ_L3_W
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tlq_pkg::tlq_qop_type               op,
   input  wire logic [$clog2(QUEUE_DEPTH)-1:0]     rd_idx,
   input  wire logic [$clog2(QUEUE_DEPTH)-1:0]     wr_idx,
   input  wire logic [ENTRY_W-1:0]                 wr_data,
   output logic      [ENTRY_W-1:0]                 rd_data,
   output logic      [$clog2(QUEUE_DEPTH+1)-1:0]   count
);
   import tlq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W:0]   DEPTH_WIDE = (IDX_W + 1)'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(QUEUE_DEPTH - 1);

   logic [ENTRY_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   rd_phys, wr_phys;
   logic [IDX_W:0]     rd_sum, wr_sum;

   // Logical to physical address: head plus offset, wrapped once.
   always_comb begin
      rd_sum = {1'b0, head_ff} + {1'b0, rd_idx};
      wr_sum = {1'b0, head_ff} + {1'b0, wr_idx};
      if (rd_sum >= DEPTH_WIDE) begin
         rd_sum = rd_sum - DEPTH_WIDE;
      end
      if (wr_sum >= DEPTH_WIDE) begin
         wr_sum = wr_sum - DEPTH_WIDE;
      end
      rd_phys = rd_sum[IDX_W-1:0];
      wr_phys = wr_sum[IDX_W-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (op.pop) begin
         head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
         count_in = count_ff - CNT_W'(1);
      end else if (op.push) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op.wr_en) begin
         mem_ff[wr_phys] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_phys];
   end

   assign rd_data = rd_data_ff;
   assign count   = count_ff;

endmodule

`default_nettype wire

/* hdl/tlq_seq.sv */
// Sequencer of the scheduler: decides each item, walks sorted inserts one entry
// a cycle through a single shared comparator. Uses tlq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlq_seq #(
   parameter int QUEUE_DEPTH = tlq_pkg::TLQ_QUEUE_DEPTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire tlq_pkg::tlq_req_type                    item,
   input  wire logic [tlq_pkg::TLQ_CSR_BITS-1:0]        high_thr,
   input  wire logic [tlq_pkg::TLQ_CSR_BITS-1:0]        low_thr,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]        count_one,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]        count_two,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]        count_three,
   input  wire logic [tlq_pkg::TLQ_L1_W-1:0]            rd_data_one,
   input  wire logic [tlq_pkg::TLQ_L2_W-1:0]            rd_data_two,
   input  wire logic [tlq_pkg::TLQ_L3_W-1:0]            rd_data_three,
   input  wire logic                                    out_free,
   output logic                                         idle,
   output logic                                         done,
   output tlq_pkg::tlq_rsp_type                         result,
   output logic      [$clog2(QUEUE_DEPTH)-1:0]          rd_idx,
   output logic      [$clog2(QUEUE_DEPTH)-1:0]          wr_idx,
   output logic                                         wr_shift,
   output tlq_pkg::tlq_qop_type                         qop_one,
   output tlq_pkg::tlq_qop_type                         qop_two,
   output tlq_pkg::tlq_qop_type                         qop_three
);
   import tlq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   tlq_state_type state_ff, state_in;
   logic [1:0]       lvl_ff, lvl_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   tlq_rsp_type      res_ff, res_in;

   tlq_mode_type     mode;
   logic             prio_hi, prio_lo;
   logic [1:0]       ins_lvl;
   logic [CNT_W-1:0] ins_cnt, ins_cnt_m1;
   logic             ins_full, ins_direct;
   logic             ne_one, ne_two, ne_three;
   logic [1:0]       front_lvl;
   logic             blk_go, yld_go;
   logic             take;
   logic [TLQ_ID_BITS-1:0]    front_id;
   logic [TLQ_BURST_BITS-1:0] cmp_a, cmp_b;
   logic             cmp_lt;
   logic [1:0]       act_lvl;
   tlq_qop_type      act_op;

   assign mode    = tlq_mode_type'(item.mode);
   assign prio_hi = item.priority_req >= high_thr;
   assign prio_lo = item.priority_req >= low_thr;
   assign ins_lvl = prio_hi ? TLQ_LVL_ONE : (prio_lo ? TLQ_LVL_TWO : TLQ_LVL_THREE);

   always_comb begin
      case (ins_lvl)
         TLQ_LVL_ONE: ins_cnt = count_one;
         TLQ_LVL_TWO: ins_cnt = count_two;
         default:     ins_cnt = count_three;
      endcase
   end

   assign ins_cnt_m1 = ins_cnt - CNT_W'(1);
   assign ins_full   = ins_cnt == DEPTH_CNT;
   // Level three appends at its tail, and an empty sorted level needs no walk.
   assign ins_direct = (ins_lvl == TLQ_LVL_THREE) || (ins_cnt == '0);

   assign ne_one    = count_one != '0;
   assign ne_two    = count_two != '0;
   assign ne_three  = count_three != '0;
   assign front_lvl = ne_one ? TLQ_LVL_ONE : (ne_two ? TLQ_LVL_TWO : TLQ_LVL_THREE);
   assign blk_go    = ne_one || ne_two || ne_three;
   assign yld_go    = ne_one || (!prio_lo && (ne_two || ne_three));

   // The shared comparator. Walking level two compares priorities; walking
   // level one and the yield check compare bursts.
   always_comb begin
      if (state_ff == TLQ_SCAN && lvl_ff == TLQ_LVL_TWO) begin
         cmp_a = TLQ_BURST_BITS'(rd_data_two[TLQ_PRIO_BITS-1:0]);
         cmp_b = TLQ_BURST_BITS'(item.priority_req);
      end else begin
         cmp_a = item.burst;
         cmp_b = rd_data_one[TLQ_BURST_BITS-1:0];
      end
   end
   assign cmp_lt = cmp_a < cmp_b;

   // A yielding thread keeps the processor when it beats the front of level one.
   assign take = !(mode == TLQ_MODE_YIELD && lvl_ff == TLQ_LVL_ONE && prio_hi && cmp_lt);

   always_comb begin
      case (lvl_ff)
         TLQ_LVL_ONE: front_id = rd_data_one[TLQ_L1_W-1 -: TLQ_ID_BITS];
         TLQ_LVL_TWO: front_id = rd_data_two[TLQ_L2_W-1 -: TLQ_ID_BITS];
         default:     front_id = rd_data_three;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TLQ_IDLE: begin
            if (start) begin
               state_in = TLQ_DECIDE;
            end
         end
         TLQ_DECIDE: begin
            unique case (mode)
               TLQ_MODE_INSERT: state_in = (ins_full || ins_direct) ? TLQ_RESP : TLQ_SCAN;
               TLQ_MODE_BLOCK:  state_in = blk_go ? TLQ_FRONT : TLQ_RESP;
               TLQ_MODE_YIELD:  state_in = yld_go ? TLQ_FRONT : TLQ_RESP;
               default:         state_in = TLQ_RESP;
            endcase
         end
         TLQ_SCAN: begin
            if (!cmp_lt) begin
               state_in = TLQ_RESP;
            end else if (pos_ff == IDX_W'(1)) begin
               state_in = TLQ_PLACE;
            end
         end
         TLQ_PLACE: state_in = TLQ_RESP;
         TLQ_FRONT: state_in = TLQ_RESP;
         TLQ_RESP: begin
            if (out_free) begin
               state_in = TLQ_IDLE;
            end
         end
         default: state_in = TLQ_IDLE;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      act_lvl  = lvl_ff;
      act_op   = '0;
      rd_idx   = '0;
      wr_idx   = pos_ff;
      wr_shift = 1'b0;
      pos_in   = pos_ff;
      lvl_in   = lvl_ff;
      res_in   = res_ff;
      done     = 1'b0;
      unique case (state_ff)
         TLQ_IDLE: begin
         end
         TLQ_DECIDE: begin
            res_in = '0;
            unique case (mode)
               TLQ_MODE_INSERT: begin
                  res_in.queued_level = ins_lvl;
                  res_in.queue_full   = ins_full;
                  act_lvl             = ins_lvl;
                  lvl_in              = ins_lvl;
                  pos_in              = ins_cnt[IDX_W-1:0];
                  rd_idx              = ins_cnt_m1[IDX_W-1:0];
                  wr_idx              = ins_cnt[IDX_W-1:0];
                  if (!ins_full && ins_direct) begin
                     act_op.wr_en = 1'b1;
                     act_op.push  = 1'b1;
                  end
               end
               TLQ_MODE_BLOCK: begin
                  lvl_in = front_lvl;
               end
               TLQ_MODE_YIELD: begin
                  lvl_in = front_lvl;
               end
               default: begin
               end
            endcase
         end
         TLQ_SCAN: begin
            if (cmp_lt) begin
               // Move the entry ahead of the gap one place back.
               act_op.wr_en = 1'b1;
               wr_shift     = 1'b1;
               pos_in       = pos_ff - IDX_W'(1);
               rd_idx       = pos_ff - IDX_W'(2);
            end else begin
               act_op.wr_en = 1'b1;
               act_op.push  = 1'b1;
            end
         end
         TLQ_PLACE: begin
            act_op.wr_en = 1'b1;
            act_op.push  = 1'b1;
         end
         TLQ_FRONT: begin
            if (take) begin
               act_op.pop            = 1'b1;
               res_in.switch_valid   = 1'b1;
               res_in.next_thread_id = front_id;
               res_in.from_level     = lvl_ff;
            end
         end
         TLQ_RESP: begin
            done = out_free;
         end
         default: begin
         end
      endcase
   end

   assign qop_one   = (act_lvl == TLQ_LVL_ONE)   ? act_op : '0;
   assign qop_two   = (act_lvl == TLQ_LVL_TWO)   ? act_op : '0;
   assign qop_three = (act_lvl == TLQ_LVL_THREE) ? act_op : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TLQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      pos_ff <= pos_in;
      res_ff <= res_in;
   end

   assign idle   = state_ff == TLQ_IDLE;
   assign result = res_ff;

endmodule

`default_nettype wire

/* hdl/three_level_ready_queue_scheduler_unit.sv */
// Top level of the three-level ready-queue scheduler: threshold registers,
// input and result registers, three level stores and the sequencer.
// Depends on tlq_pkg, tlq_queue and tlq_seq.
`timescale 1ns / 1ps
`default_nettype none

// This block keeps three ready queues of QUEUE_DEPTH threads each. An insert
// item places a thread by priority: at or above high_threshold it joins level
// one, sorted by ascending burst estimate; at or above low_threshold it joins
// level two, sorted by descending priority; otherwise it is appended to the
// first-in first-out level three. Equal entries keep their arrival order. A
// full target level drops the thread and sets queue_full. A select item takes
// the front of the highest non-empty level, and a yield select keeps the
// current thread when it should not be preempted. Every item yields exactly
// one result item. The block works on one item at a time, and req_stall is
// high from the cycle after acceptance until the result has been loaded into
// the output register. A level-three insert, an insert into an empty sorted
// level, a dropped insert, an item of the unused mode and a select that finds
// no queue front go from decide straight to the result. A select that reads a
// queue front adds a front step, whether it takes that thread or a yielding
// thread keeps the processor. An insert into a non-empty sorted level adds a
// scan step per queued entry that sorts behind the new thread and one step
// that writes it. Each level's memory has a single read and write port: one
// entry is compared and moved per cycle. No clearing pass runs after reset.
// Thresholds must be written through the csr port only while the block is
// idle, by the user; the block itself does not enforce this.
module three_level_ready_queue_scheduler_unit #(
   parameter int QUEUE_DEPTH = tlq_pkg::TLQ_QUEUE_DEPTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire tlq_pkg::tlq_req_type                  req_payload,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output tlq_pkg::tlq_rsp_type                       rsp_payload,
   input  wire logic                                  csr_wr_en,
   input  wire logic [tlq_pkg::TLQ_CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tlq_pkg::TLQ_CSR_BITS-1:0]      csr_wdata
);
   import tlq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Threshold registers.
   logic [TLQ_CSR_BITS-1:0] high_thr_ff, high_thr_in;
   logic [TLQ_CSR_BITS-1:0] low_thr_ff, low_thr_in;

   // The accepted item stays here while the sequencer works on it.
   tlq_req_type item_ff, item_in;
   logic        req_accept;

   // Result register, which parts the sequencer from the result channel.
   logic        rsp_valid_ff, rsp_valid_in;
   tlq_rsp_type rsp_payload_ff, rsp_payload_in;
   logic        out_free;

   logic        seq_idle, seq_done;
   tlq_rsp_type seq_result;
   logic [IDX_W-1:0] rd_idx, wr_idx;
   logic        wr_shift;
   tlq_qop_type qop_one, qop_two, qop_three;

   logic [CNT_W-1:0]    count_one, count_two, count_three;
   logic [TLQ_L1_W-1:0] rd_data_one, wr_data_one;
   logic [TLQ_L2_W-1:0] rd_data_two, wr_data_two;
   logic [TLQ_L3_W-1:0] rd_data_three, wr_data_three;

   always_comb begin
      high_thr_in = high_thr_ff;
      low_thr_in  = low_thr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            TLQ_CSR_HIGH_THR: high_thr_in = csr_wdata;
            TLQ_CSR_LOW_THR:  low_thr_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_thr_ff <= TLQ_HIGH_THR_RESET;
         low_thr_ff  <= TLQ_LOW_THR_RESET;
      end else begin
         high_thr_ff <= high_thr_in;
         low_thr_ff  <= low_thr_in;
      end
   end

   assign req_stall  = !seq_idle;
   assign req_accept = req_valid && !req_stall;
   assign item_in    = req_accept ? req_payload : item_ff;

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // A new result may load when the register is empty or being taken.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (seq_done) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = seq_result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A walk step rewrites the entry just read one place further back; any
   // other write stores the new thread.
   assign wr_data_one   = wr_shift ? rd_data_one : {item_ff.thread_id, item_ff.burst};
   assign wr_data_two   = wr_shift ? rd_data_two : {item_ff.thread_id, item_ff.priority_req};
   assign wr_data_three = item_ff.thread_id;

   tlq_seq #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (req_accept),
      .item         (item_ff),
      .high_thr     (high_thr_ff),
      .low_thr      (low_thr_ff),
      .count_one    (count_one),
      .count_two    (count_two),
      .count_three  (count_three),
      .rd_data_one  (rd_data_one),
      .rd_data_two  (rd_data_two),
      .rd_data_three(rd_data_three),
      .out_free     (out_free),
      .idle         (seq_idle),
      .done         (seq_done),
      .result       (seq_result),
      .rd_idx       (rd_idx),
      .wr_idx       (wr_idx),
      .wr_shift     (wr_shift),
      .qop_one      (qop_one),
      .qop_two      (qop_two),
      .qop_three    (qop_three)
   );

   tlq_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ENTRY_W    (TLQ_L1_W)
   ) u_level_one (
      .clock  (clock),
      .reset  (reset),
      .op     (qop_one),
      .rd_idx (rd_idx),
      .wr_idx (wr_idx),
      .wr_data(wr_data_one),
      .rd_data(rd_data_one),
      .count  (count_one)
   );

   tlq_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ENTRY_W    (TLQ_L2_W)
   ) u_level_two (
      .clock  (clock),
      .reset  (reset),
      .op     (qop_two),
      .rd_idx (rd_idx),
      .wr_idx (wr_idx),
      .wr_data(wr_data_two),
      .rd_data(rd_data_two),
      .count  (count_two)
   );

   tlq_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ENTRY_W    (TLQ_L3_W)
   ) u_level_three (
      .clock  (clock),
      .reset  (reset),
      .op     (qop_three),
      .rd_idx (rd_idx),
      .wr_idx (wr_idx),
      .wr_data(wr_data_three),
      .rd_data(rd_data_three),
      .count  (count_three)
   );

   // Only one item is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("item accepted while another was still in work");

   // Queue fill counts move only while an item is in work.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_one != $past(count_one) || count_two != $past(count_two)
         || count_three != $past(count_three))) |-> $past(req_stall))
      else $error("queue fill count changed while idle");

   // A dropped insert never reports a switch.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.queue_full && rsp_payload.switch_valid))
      else $error("result reports both a drop and a switch");

   // A new result appears only as the end of an item's work.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in work");

endmodule

`default_nettype wire

/* bench/tlq_sched_check_pkg.sv */
// Scoreboard for the three-level ready-queue scheduler testbench: a predictor of
// the three ready queues and the thresholds, and a result checker.
// Depends on tlq_pkg for the payload structs, codes and reset values.
`timescale 1ns / 1ps

package tlq_sched_check_pkg;

   import tlq_pkg::*;

   typedef struct packed {
      logic [TLQ_ID_BITS-1:0]    id;
      logic [TLQ_BURST_BITS-1:0] burst;
   } burst_entry_type;

   typedef struct packed {
      logic [TLQ_ID_BITS-1:0]   id;
      logic [TLQ_PRIO_BITS-1:0] prio;
   } prio_entry_type;

   class sched_scoreboard;
      logic [TLQ_CSR_BITS-1:0]   high_thr;
      logic [TLQ_CSR_BITS-1:0]   low_thr;
      burst_entry_type           level_one[$];
      prio_entry_type            level_two[$];
      logic [TLQ_ID_BITS-1:0]    level_three[$];
      tlq_rsp_type               pending_decisions[$];
      int unsigned               mismatches;

      function new();
         high_thr   = TLQ_HIGH_THR_RESET;
         low_thr    = TLQ_LOW_THR_RESET;
         mismatches = 0;
      endfunction

      function void write_threshold(logic [TLQ_CSR_IDX_W-1:0] index,
                                    logic [TLQ_CSR_BITS-1:0] value);
         if (index == TLQ_CSR_HIGH_THR) begin
            high_thr = value;
         end else begin
            low_thr = value;
         end
      endfunction

      // Removes the front thread of one level and reports it as a switch.
      function tlq_rsp_type take_front(logic [1:0] level);
         tlq_rsp_type     taken;
         burst_entry_type b_entry;
         prio_entry_type  p_entry;
         taken = '0;
         taken.switch_valid = 1'b1;
         taken.from_level   = level;
         if (level == TLQ_LVL_ONE) begin
            b_entry = level_one.pop_front();
            taken.next_thread_id = b_entry.id;
         end else if (level == TLQ_LVL_TWO) begin
            p_entry = level_two.pop_front();
            taken.next_thread_id = p_entry.id;
         end else begin
            taken.next_thread_id = level_three.pop_front();
         end
         return taken;
      endfunction

      // Updates the queues for one accepted item and returns its decision.
      function tlq_rsp_type schedule_item(tlq_req_type item);
         tlq_rsp_type     decision;
         burst_entry_type b_entry;
         prio_entry_type  p_entry;
         int              pos;
         decision = '0;
         case (item.mode)
            TLQ_MODE_INSERT: begin
               if (item.priority_req >= high_thr) begin
                  decision.queued_level = TLQ_LVL_ONE;
                  if (level_one.size() >= TLQ_QUEUE_DEPTH) begin
                     decision.queue_full = 1'b1;
                  end else begin
                     // Equal bursts keep arrival order, so walk past them.
                     pos = 0;
                     while (pos < level_one.size() && level_one[pos].burst <= item.burst)
                        pos++;
                     b_entry.id    = item.thread_id;
                     b_entry.burst = item.burst;
                     level_one.insert(pos, b_entry);
                  end
               end else if (item.priority_req >= low_thr) begin
                  decision.queued_level = TLQ_LVL_TWO;
                  if (level_two.size() >= TLQ_QUEUE_DEPTH) begin
                     decision.queue_full = 1'b1;
                  end else begin
                     pos = 0;
                     while (pos < level_two.size() && level_two[pos].prio >= item.priority_req)
                        pos++;
                     p_entry.id   = item.thread_id;
                     p_entry.prio = item.priority_req;
                     level_two.insert(pos, p_entry);
                  end
               end else begin
                  decision.queued_level = TLQ_LVL_THREE;
                  if (level_three.size() >= TLQ_QUEUE_DEPTH) begin
                     decision.queue_full = 1'b1;
                  end else begin
                     level_three.push_back(item.thread_id);
                  end
               end
            end
            TLQ_MODE_BLOCK: begin
               if (level_one.size() > 0) begin
                  decision = take_front(TLQ_LVL_ONE);
               end else if (level_two.size() > 0) begin
                  decision = take_front(TLQ_LVL_TWO);
               end else if (level_three.size() > 0) begin
                  decision = take_front(TLQ_LVL_THREE);
               end
            end
            TLQ_MODE_YIELD: begin
               if (level_one.size() > 0) begin
                  // The current thread stays only if it is urgent and shorter.
                  if (!(item.priority_req >= high_thr && item.burst < level_one[0].burst))
                     decision = take_front(TLQ_LVL_ONE);
               end else if (item.priority_req < low_thr) begin
                  if (level_two.size() > 0) begin
                     decision = take_front(TLQ_LVL_TWO);
                  end else if (level_three.size() > 0) begin
                     decision = take_front(TLQ_LVL_THREE);
                  end
               end
            end
            default: begin
               // The unused mode leaves the queues alone and answers with zeros.
            end
         endcase
         return decision;
      endfunction

      function void note_request(tlq_req_type item);
         pending_decisions.push_back(schedule_item(item));
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(tlq_rsp_type got);
         tlq_rsp_type want;
         if (pending_decisions.size() == 0) begin
            $error("unexpected result item: %p", got);
            mismatches++;
            return;
         end
         want = pending_decisions.pop_front();
         compare_field("switch_valid", 16'(want.switch_valid), 16'(got.switch_valid));
         compare_field("next_thread_id", 16'(want.next_thread_id), 16'(got.next_thread_id));
         compare_field("from_level", 16'(want.from_level), 16'(got.from_level));
         compare_field("queued_level", 16'(want.queued_level), 16'(got.queued_level));
         compare_field("queue_full", 16'(want.queue_full), 16'(got.queue_full));
      endfunction
   endclass

endpackage

/* bench/three_level_ready_queue_scheduler_unit_tb.sv */
// Self-checking testbench for three_level_ready_queue_scheduler_unit.
// Depends on tlq_pkg and on the scoreboard in tlq_sched_check_pkg.
`timescale 1ns / 1ps

module three_level_ready_queue_scheduler_unit_tb;

   import tlq_pkg::*;
   import tlq_sched_check_pkg::*;

   // Mode three is not defined by the block; it must be ignored.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Shapes of the random stimulus. A fill chunk mostly inserts and aims at one
   // level so that the queues reach their depth; a drain chunk mostly selects.
   localparam int CHUNK_FILL  = 0;
   localparam int CHUNK_DRAIN = 1;
   localparam int CHUNK_MIXED = 2;

   localparam int PHASE_COUNT      = 8;
   localparam int ITEMS_PER_PHASE  = 100;
   localparam int IDLE_PERCENT     = 21;
   localparam int LONG_HOLD_CYCLES = 300;
   // The longest occupancy is a sorted insert that walks a full level.
   localparam int SETTLE_CYCLES    = 2 * TLQ_QUEUE_DEPTH + 10;

   localparam logic [TLQ_BURST_BITS-1:0] BURST_MAX = '1;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   tlq_req_type                   req_payload;
   logic                          rsp_valid;
   logic                          rsp_stall;
   tlq_rsp_type                   rsp_payload;
   logic                          csr_wr_en;
   logic [TLQ_CSR_IDX_W-1:0]      csr_index;
   logic [TLQ_CSR_BITS-1:0]       csr_wdata;

   sched_scoreboard               sb;

   // Shared between the stimulus and the result side.
   bit                            no_idle = 1'b0;
   bit                            hold_request = 1'b0;

   three_level_ready_queue_scheduler_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side. Every accepted result item is checked against the oldest
   // prediction. The stall is random except during a no-idle stretch and
   // during one long hold-off, which is counted here so that the sender keeps
   // offering items while the block backs up and stalls its input.
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_response(rsp_payload);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // The run ends here if the block hangs.
   initial begin : watchdog
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // Random sender gaps: roughly one cycle in five is left empty.
   task automatic sender_gap();
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Offers one item and returns at the edge where it is taken. Valid is left
   // high so that a following item goes out without a bubble.
   task automatic send_item(tlq_req_type item);
      req_valid   <= 1'b1;
      req_payload <= item;
      do
         @(posedge clock);
      while (req_stall);
      sb.note_request(item);
   endtask

   task automatic offer(logic [1:0] mode, logic [TLQ_ID_BITS-1:0] id,
                        logic [TLQ_PRIO_BITS-1:0] prio, logic [TLQ_BURST_BITS-1:0] burst);
      tlq_req_type item;
      item.mode         = mode;
      item.thread_id    = id;
      item.priority_req = prio;
      item.burst        = burst;
      sender_gap();
      send_item(item);
   endtask

   // Stops offering and waits until every predicted result has been checked.
   // Every item produces a result, so the block is idle at that point.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_decisions.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   // Writes the high threshold, then the low threshold, on consecutive edges.
   task automatic write_thresholds(logic [TLQ_CSR_BITS-1:0] high_value,
                                   logic [TLQ_CSR_BITS-1:0] low_value);
      csr_wr_en <= 1'b1;
      csr_index <= TLQ_CSR_HIGH_THR;
      csr_wdata <= high_value;
      @(posedge clock);
      sb.write_threshold(TLQ_CSR_HIGH_THR, high_value);
      csr_index <= TLQ_CSR_LOW_THR;
      csr_wdata <= low_value;
      @(posedge clock);
      sb.write_threshold(TLQ_CSR_LOW_THR, low_value);
      csr_wr_en <= 1'b0;
   endtask

   // Priorities cluster on both thresholds, where the level decisions flip.
   function automatic logic [TLQ_PRIO_BITS-1:0] pick_priority();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 25)
         return sb.high_thr + 8'($urandom_range(2)) - 8'd1;
      else if (pick < 50)
         return sb.low_thr + 8'($urandom_range(2)) - 8'd1;
      else if (pick < 60)
         return ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
      return 8'($urandom_range(255));
   endfunction

   // A priority that lands in the given level under the current thresholds,
   // when the thresholds leave room for that level at all.
   function automatic logic [TLQ_PRIO_BITS-1:0] priority_for_level(logic [1:0] level);
      if (level == TLQ_LVL_ONE)
         return 8'($urandom_range(255, sb.high_thr));
      if (level == TLQ_LVL_TWO && sb.low_thr < sb.high_thr)
         return 8'($urandom_range(sb.high_thr - 1, sb.low_thr));
      if (level == TLQ_LVL_THREE && sb.low_thr > 0)
         return 8'($urandom_range(sb.low_thr - 1, 0));
      return pick_priority();
   endfunction

   // Small bursts make ties and yield comparisons common; the rest spread
   // over the whole field.
   function automatic logic [TLQ_BURST_BITS-1:0] pick_burst();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50)
         return TLQ_BURST_BITS'($urandom_range(7));
      else if (pick < 60)
         return '0;
      else if (pick < 70)
         return BURST_MAX;
      return TLQ_BURST_BITS'($urandom());
   endfunction

   function automatic tlq_req_type make_item(int kind, logic [1:0] favored);
      tlq_req_type item;
      int unsigned insert_percent;
      int unsigned pick;
      insert_percent = (kind == CHUNK_FILL) ? 90 : (kind == CHUNK_DRAIN) ? 15 : 50;
      pick = $urandom_range(99);
      item.thread_id = TLQ_ID_BITS'($urandom_range(255));
      item.burst     = pick_burst();
      if (pick < 2) begin
         item.mode         = MODE_UNUSED;
         item.priority_req = 8'($urandom_range(255));
      end else if (pick < insert_percent) begin
         item.mode = TLQ_MODE_INSERT;
         if (kind == CHUNK_FILL && $urandom_range(99) < 70)
            item.priority_req = priority_for_level(favored);
         else
            item.priority_req = pick_priority();
      end else begin
         item.mode = ($urandom_range(1) == 0) ? TLQ_MODE_BLOCK : TLQ_MODE_YIELD;
         item.priority_req = pick_priority();
      end
      return item;
   endfunction

   // Random chunks of varying shape until the item count is used up.
   task automatic run_random(int count);
      int          remaining;
      int          kind;
      int          length;
      logic [1:0]  favored;
      remaining = count;
      while (remaining > 0) begin
         kind    = $urandom_range(2);
         length  = (kind == CHUNK_FILL) ? $urandom_range(60, 30) : $urandom_range(40, 15);
         favored = 2'($urandom_range(2));
         for (int j = 0; j < length && remaining > 0; j++) begin
            sender_gap();
            send_item(make_item(kind, favored));
            remaining--;
         end
      end
   endtask

   // Directed opening with the reset thresholds (high 100, low 50): empty
   // selects, the ignored mode, field extremes, equal-key ordering in both
   // sorted levels, every yield outcome, and the fall-through from one level
   // to the next until the queues are empty again.
   task automatic run_directed();
      offer(TLQ_MODE_BLOCK,  8'd9,   8'd0,   '0);
      offer(TLQ_MODE_YIELD,  8'd9,   8'd0,   '0);
      offer(MODE_UNUSED,     8'd255, 8'd255, BURST_MAX);
      offer(TLQ_MODE_INSERT, 8'd255, 8'd255, BURST_MAX);
      offer(TLQ_MODE_INSERT, 8'd0,   8'd100, 20'd5);
      offer(TLQ_MODE_INSERT, 8'd1,   8'd100, 20'd5);
      offer(TLQ_MODE_INSERT, 8'd2,   8'd99,  '0);
      offer(TLQ_MODE_INSERT, 8'd3,   8'd50,  '0);
      offer(TLQ_MODE_INSERT, 8'd4,   8'd99,  '0);
      offer(TLQ_MODE_INSERT, 8'd5,   8'd49,  '0);
      offer(TLQ_MODE_INSERT, 8'd6,   8'd0,   BURST_MAX);
      // Urgent and shorter than the front of level one: no switch.
      offer(TLQ_MODE_YIELD,  8'd0,   8'd100, 20'd4);
      // Below the high threshold: the front of level one is taken.
      offer(TLQ_MODE_YIELD,  8'd0,   8'd99,  '0);
      // An equal burst does not protect the current thread.
      offer(TLQ_MODE_YIELD,  8'd0,   8'd255, 20'd5);
      offer(TLQ_MODE_BLOCK,  8'd0,   8'd0,   '0);
      // Level one empty and the current thread at the low threshold: stays.
      offer(TLQ_MODE_YIELD,  8'd0,   8'd50,  BURST_MAX);
      offer(TLQ_MODE_YIELD,  8'd0,   8'd49,  '0);
      offer(TLQ_MODE_BLOCK,  8'd0,   8'd0,   '0);
      offer(TLQ_MODE_BLOCK,  8'd0,   8'd0,   '0);
      offer(TLQ_MODE_YIELD,  8'd0,   8'd0,   '0);
      offer(TLQ_MODE_BLOCK,  8'd0,   8'd0,   '0);
      offer(TLQ_MODE_BLOCK,  8'd0,   8'd0,   '0);
   endtask

   initial begin : stimulus
      logic [TLQ_CSR_BITS-1:0] high_list [PHASE_COUNT];
      logic [TLQ_CSR_BITS-1:0] low_list  [PHASE_COUNT];
      // Threshold settings per phase, including both extremes, thresholds in
      // odd order, and settings that leave a level unreachable.
      high_list = '{8'd100, 8'd0, 8'd255, 8'd200, 8'd30,  8'd255, 8'd0,   8'd0};
      low_list  = '{8'd50,  8'd0, 8'd255, 8'd10,  8'd180, 8'd0,   8'd255, 8'd0};
      high_list[PHASE_COUNT-1] = 8'($urandom_range(255));
      low_list[PHASE_COUNT-1]  = 8'($urandom_range(255));

      sb = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= TLQ_CSR_HIGH_THR;
      csr_wdata   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_thresholds(high_list[phase], low_list[phase]);
         // One phase starts with a long result hold-off, another runs with
         // no idling on either side.
         if (phase == 1)
            hold_request = 1'b1;
         no_idle = (phase == 3);
         run_random(ITEMS_PER_PHASE);
         // The sender waits here until every result has come back.
         drain();
      end
      no_idle = 1'b0;

      // Anything the block still emits now is an unexpected result.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_decisions.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
